// ----- sv/bsme_pkg.sv -----
// ----------------------------------------------------------------------------
// bsme_pkg
// Shared types and constants of the bitmap sparse matrix encoder.
// ----------------------------------------------------------------------------
package bsme_pkg;

  localparam int ELEM_W       = 32;
  localparam int ROW_COUNT_W  = 9;
  localparam int COL_COUNT_W  = 11;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int POS_W        = 13;
  localparam int SEG_CNT_W    = 12;
  localparam int OFFSET_W     = 14;
  localparam int NUM_GROUPS   = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd4;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 11'd32;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_BITMAP = 2'd1,
    KIND_OFFSET = 2'd2
  } kind_t;

  // everything one element word produces, before serialization
  typedef struct packed {
    logic                                 nz_valid;
    logic [ELEM_W-1:0]                    nz_bits;
    logic [SEG_CNT_W-1:0]                 nz_pos;
    logic                                 bm_valid;
    logic [31:0]                          bm_word;
    logic [POS_W-1:0]                     bm_pos;
    logic                                 off_valid;
    logic [NUM_GROUPS-1:0][OFFSET_W-1:0]  offsets;
    logic [4:0]                           block;
    logic [1:0]                           group;
  } bundle_t;

endpackage

// ----- sv/bsme_intf.sv -----
// ----------------------------------------------------------------------------
// bsme_intf
// Valid/ready channels of the encoder: element, result and config write.
// ----------------------------------------------------------------------------
interface bsme_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_bits;

  modport source (output valid, output element_bits, input ready);
  modport sink (input valid, input element_bits, output ready);
endinterface

interface bsme_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] payload;
  logic [12:0] position;
  logic [4:0]  column_block;
  logic [1:0]  row_group;
  logic        last;

  modport source (output valid, output kind, output payload, output position,
                  output column_block, output row_group, output last, input ready);
  modport sink (input valid, input kind, input payload, input position,
                input column_block, input row_group, input last, output ready);
endinterface

interface bsme_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/bsme_scan.sv -----
// ----------------------------------------------------------------------------
// bsme_scan
// Scan position counters, bitmap and segment counts; forms the result bundle
// of one element word in the cycle it is accepted.
// ----------------------------------------------------------------------------
module bsme_scan #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [bsme_pkg::ELEM_W-1:0]        element_bits,
  input  logic [bsme_pkg::ROW_COUNT_W-1:0]   row_count,
  input  logic [bsme_pkg::COL_COUNT_W-1:0]   column_count,
  output bsme_pkg::bundle_t                  bundle_next
);
  import bsme_pkg::*;

  localparam int RPG_CAP_I = (MAX_ROWS / 4 > 127) ? 127 : MAX_ROWS / 4;
  localparam int BPM_CAP_I = (MAX_COLS / 32 > 32) ? 32 : MAX_COLS / 32;
  localparam logic [6:0] RPG_CAP = 7'(RPG_CAP_I);
  localparam logic [5:0] BPM_CAP = 6'(BPM_CAP_I);

  logic [4:0]           column_in_block;
  logic [5:0]           row_in_group;
  logic [1:0]           group_number;
  logic [4:0]           block_number;
  logic [31:0]          bitmap_accumulator;
  logic [POS_W-1:0]     bitmap_word_index;
  logic [SEG_CNT_W-1:0] segment_nonzero_count;
  logic [SEG_CNT_W-1:0] group_max_count [NUM_GROUPS];

  logic [6:0]           rows_per_group;
  logic [5:0]           blocks_per_matrix;
  logic                 nz;
  logic [SEG_CNT_W-1:0] seg_inc;
  logic [31:0]          acc_or;
  logic                 end_row;
  logic                 end_grp;
  logic                 end_mat;
  logic [SEG_CNT_W-1:0] max_upd [NUM_GROUPS];
  logic [OFFSET_W-1:0]  sum [NUM_GROUPS];

  always_comb begin
    rows_per_group = row_count[8:2];
    if (rows_per_group == 7'd0) rows_per_group = 7'd1;
    if (rows_per_group > RPG_CAP) rows_per_group = RPG_CAP;
    blocks_per_matrix = column_count[10:5];
    if (blocks_per_matrix == 6'd0) blocks_per_matrix = 6'd1;
    if (blocks_per_matrix > BPM_CAP) blocks_per_matrix = BPM_CAP;
  end

  assign nz      = |element_bits[30:0];  // -0.0 counts as zero
  assign seg_inc = segment_nonzero_count + SEG_CNT_W'(nz);
  assign acc_or  = bitmap_accumulator | (32'(nz) << column_in_block);
  assign end_row = column_in_block == 5'd31;
  assign end_grp = end_row && (({1'b0, row_in_group} + 7'd1) >= rows_per_group);
  assign end_mat = end_grp && (group_number == 2'd3)
                   && (({1'b0, block_number} + 6'd1) >= blocks_per_matrix);

  always_comb begin
    for (int i = 0; i < NUM_GROUPS; i++) begin
      max_upd[i] = group_max_count[i];
      if (end_grp && group_number == 2'(i) && seg_inc > group_max_count[i])
        max_upd[i] = seg_inc;
    end
    sum[0] = OFFSET_W'(max_upd[0]);
    for (int i = 1; i < NUM_GROUPS; i++) begin
      sum[i] = sum[i-1] + OFFSET_W'(max_upd[i]);
    end
  end

  always_comb begin
    bundle_next.nz_valid  = nz;
    bundle_next.nz_bits   = element_bits;
    bundle_next.nz_pos    = segment_nonzero_count;
    bundle_next.bm_valid  = end_row;
    bundle_next.bm_word   = acc_or;
    bundle_next.bm_pos    = bitmap_word_index;
    bundle_next.off_valid = end_mat;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      bundle_next.offsets[i] = sum[i];
    end
    bundle_next.block     = block_number;
    bundle_next.group     = group_number;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_in_block       <= '0;
      row_in_group          <= '0;
      group_number          <= '0;
      block_number          <= '0;
      bitmap_accumulator    <= '0;
      bitmap_word_index     <= '0;
      segment_nonzero_count <= '0;
      for (int i = 0; i < NUM_GROUPS; i++) group_max_count[i] <= '0;
    end else if (step) begin
      column_in_block       <= end_row ? 5'd0 : column_in_block + 5'd1;
      bitmap_accumulator    <= end_row ? 32'd0 : acc_or;
      segment_nonzero_count <= end_grp ? '0 : seg_inc;
      if (end_mat) begin
        bitmap_word_index <= '0;
      end else if (end_row) begin
        bitmap_word_index <= bitmap_word_index + POS_W'(1);
      end
      if (end_row) begin
        row_in_group <= end_grp ? 6'd0 : row_in_group + 6'd1;
      end
      if (end_grp) begin
        group_number <= group_number + 2'd1;  // 3 wraps to 0
        if (group_number == 2'd3) begin
          block_number <= end_mat ? 5'd0 : block_number + 5'd1;
        end
      end
      for (int i = 0; i < NUM_GROUPS; i++) begin
        group_max_count[i] <= end_mat ? '0 : max_upd[i];
      end
    end
  end

endmodule

// ----- sv/bitmap_sparse_matrix_encoder_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_sparse_matrix_encoder_core
// Streams float matrix elements in, emits nonzeros, bitmap words and padded
// group offsets.
// ----------------------------------------------------------------------------
//  port    | dir | word
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | element_bits
//  out_ch  | out | kind, payload, position, column_block, row_group, last
//  cfg     | in  | index, data (0 row_count, 1 column_count); always ready
//
// An accepted element yields zero to six results, which leave one per
// cycle from the output register, so a run of elements with one result each
// streams at one per cycle, and the output port's one word per cycle sets
// the rate otherwise. A stall on out_ch holds the result bundle and then
// in_ch. Synchronous reset clears counters, maxima and handshake state.
module bitmap_sparse_matrix_encoder_core #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  bsme_elem_if.sink  in_ch,
  bsme_res_if.source out_ch,
  bsme_cfg_if.sink   cfg
);
  import bsme_pkg::*;

  logic [ROW_COUNT_W-1:0] row_count;
  logic [COL_COUNT_W-1:0] column_count;

  bundle_t       bundle_next;
  bundle_t       bundle;
  logic [5:0]    pend;       // nz, bitmap, offset 0..3
  logic [5:0]    pend_rest;
  logic          emit;
  logic          accept;
  logic [1:0]    off_idx;

  logic          out_valid;
  kind_t         out_kind;
  logic [31:0]   out_payload;
  logic [12:0]   out_position;
  logic [4:0]    out_block;
  logic [1:0]    out_group;
  logic          out_last;

  kind_t         sel_kind;
  logic [31:0]   sel_payload;
  logic [12:0]   sel_position;
  logic [1:0]    sel_group;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COL_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROW_COUNT:    row_count    <= cfg.data[ROW_COUNT_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg.data;
        default: ;
      endcase
    end
  end

  bsme_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .element_bits (in_ch.element_bits),
    .row_count    (row_count),
    .column_count (column_count),
    .bundle_next  (bundle_next)
  );

  // serialize the bundle, lowest pending result first
  assign pend_rest   = pend & (pend - 6'd1);
  assign emit        = (|pend) && (!out_valid || out_ch.ready);
  assign in_ch.ready = (pend == 6'd0) || (emit && pend_rest == 6'd0);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    off_idx = 2'd3;
    if (pend[2]) off_idx = 2'd0;
    else if (pend[3]) off_idx = 2'd1;
    else if (pend[4]) off_idx = 2'd2;

    if (pend[0]) begin
      sel_kind     = KIND_VALUE;
      sel_payload  = bundle.nz_bits;
      sel_position = POS_W'(bundle.nz_pos);
      sel_group    = bundle.group;
    end else if (pend[1]) begin
      sel_kind     = KIND_BITMAP;
      sel_payload  = bundle.bm_word;
      sel_position = bundle.bm_pos;
      sel_group    = bundle.group;
    end else begin
      sel_kind     = KIND_OFFSET;
      sel_payload  = 32'(bundle.offsets[off_idx]);
      sel_position = POS_W'(off_idx);
      sel_group    = off_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= {{4{bundle_next.off_valid}}, bundle_next.bm_valid, bundle_next.nz_valid};
      end else if (emit) begin
        pend <= pend_rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bundle <= bundle_next;
    end
    if (emit) begin
      out_kind     <= sel_kind;
      out_payload  <= sel_payload;
      out_position <= sel_position;
      out_block    <= bundle.block;
      out_group    <= sel_group;
      out_last     <= pend_rest == 6'd0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_kind;
  assign out_ch.payload      = out_payload;
  assign out_ch.position     = out_position;
  assign out_ch.column_block = out_block;
  assign out_ch.row_group    = out_group;
  assign out_ch.last         = out_last;

`ifndef NO_ASSERTIONS
  // a new word only enters once the previous bundle is down to its last result
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    accept |-> $countones(pend) <= 1)
    else $error("element taken while results still pending");

  a_offsets_queued: assert property (@(posedge clk) disable iff (rst)
    accept && bundle_next.off_valid |=> pend[5:2] == 4'hF)
    else $error("group offsets not queued after final element");

  a_offset_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_OFFSET |-> out_position == POS_W'(out_group))
    else $error("offset position and row group disagree");

  a_offset_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_OFFSET |-> out_last == (out_group == 2'd3))
    else $error("last flag wrong on group offsets");
`endif

endmodule
